// ----- hw/rtl/sitda_pkg.sv -----
package sitda_pkg;

   // widths of the payload
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CHAR_W  = 8;

   // decimal working store: ten bcd digits cover any 32-bit magnitude
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned BCD_W      = DIGIT_W * NUM_DIGITS;

   // ascii codes
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   // largest legal digit and the add-3 threshold of the shift-add-3 scheme
   localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
   localparam logic [DIGIT_W-1:0] ADJ_THRESH = 4'd5;
   localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd3;

   typedef logic [BCD_W-1:0]   bcd_type;
   typedef logic [DIGIT_W-1:0] digit_type;

endpackage

// ----- hw/rtl/signed_int_to_decimal_ascii_core.sv -----
// channel  | ports                                   | beat
// ---------+-----------------------------------------+-------------------------------
// request  | req_valid, req_ready, req_value         | one signed 32-bit integer
// response | rsp_valid, rsp_ready, rsp_text_char,    | one ascii character, is_last
//          | rsp_is_last                             | set on the final one
//
// one item passes a load step, the shift-add-3 loop over all 32 input bits,
// a step that drops leading zero digits, then emits one character per cycle
// while the consumer is ready (sign first, then digits).
// a new item is taken once the last character sits in the output register.
// reset clears the state and the output valid; the data registers are not reset.
// a stalled response holds the character loop; nothing is dropped.
module signed_int_to_decimal_ascii_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [sitda_pkg::VALUE_W-1:0] req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sitda_pkg::CHAR_W-1:0]   rsp_text_char,
   output logic                           rsp_is_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SKIP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam int unsigned CNT_W = $clog2(sitda_pkg::VALUE_W);
   localparam int unsigned DCNT_W = $clog2(sitda_pkg::NUM_DIGITS + 1);
   localparam logic [CNT_W-1:0]  BIT_LAST   = CNT_W'(sitda_pkg::VALUE_W - 1);
   localparam logic [DCNT_W-1:0] DIGITS_ALL = DCNT_W'(sitda_pkg::NUM_DIGITS);
   localparam logic [DCNT_W-1:0] DIGITS_ONE = DCNT_W'(1);

   logic [1:0]                      state_ff, state_in;
   logic [sitda_pkg::VALUE_W-1:0]   mag_ff, mag_in;
   logic                            neg_ff, neg_in;
   sitda_pkg::bcd_type              bcd_ff, bcd_in;
   logic [CNT_W-1:0]                bit_cnt_ff, bit_cnt_in;
   logic [DCNT_W-1:0]               dig_cnt_ff, dig_cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sitda_pkg::CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                            rsp_last_ff, rsp_last_in;

   sitda_pkg::bcd_type              bcd_adj;
   sitda_pkg::digit_type            top_digit;
   logic [sitda_pkg::VALUE_W-1:0]   raw;
   logic                            out_free;
   logic                            req_fire;
   logic                            bcd_ok;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign raw       = unsigned'(req_value);
   assign top_digit = bcd_ff[sitda_pkg::BCD_W-1 -: sitda_pkg::DIGIT_W];

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] >= sitda_pkg::ADJ_THRESH) begin
            bcd_adj[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
               bcd_ff[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + sitda_pkg::ADJ_ADD;
         end else begin
            bcd_adj[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
               bcd_ff[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
         end
      end
   end

   // sequencer: load, convert, drop leading zeros, emit
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in     = raw[sitda_pkg::VALUE_W-1];
               mag_in     = raw[sitda_pkg::VALUE_W-1] ? (0 - raw) : raw;
               bcd_in     = '0;
               bit_cnt_in = '0;
               dig_cnt_in = DIGITS_ALL;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[sitda_pkg::BCD_W-2:0], mag_ff[sitda_pkg::VALUE_W-1]};
            mag_in     = {mag_ff[sitda_pkg::VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // keep at least one digit so zero prints as '0'
            if (top_digit == '0 && dig_cnt_ff != DIGITS_ONE) begin
               bcd_in     = {bcd_ff[sitda_pkg::BCD_W-sitda_pkg::DIGIT_W-1:0],
                             sitda_pkg::DIGIT_W'(0)};
               dig_cnt_in = dig_cnt_ff - DIGITS_ONE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_char_in = sitda_pkg::CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  neg_in      = 1'b0;
               end else begin
                  rsp_char_in = sitda_pkg::CHAR_ZERO + {4'h0, top_digit};
                  rsp_last_in = (dig_cnt_ff == DIGITS_ONE);
                  bcd_in      = {bcd_ff[sitda_pkg::BCD_W-sitda_pkg::DIGIT_W-1:0],
                                 sitda_pkg::DIGIT_W'(0)};
                  dig_cnt_in  = dig_cnt_ff - DIGITS_ONE;
                  if (dig_cnt_ff == DIGITS_ONE) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // every bcd digit stays a legal decimal digit
   always_comb begin
      bcd_ok = 1'b1;
      for (int i = 0; i < sitda_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] > sitda_pkg::DIGIT_MAX) begin
            bcd_ok = 1'b0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   // a taken request starts the conversion loop
   a_fire_to_conv: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_CONV)
      else $error("request beat did not start conversion");

   // shift-add-3 keeps the digits decimal
   a_bcd_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && !(state_ff == ST_CONV && bit_cnt_ff == '0)) |-> bcd_ok)
      else $error("bcd digit out of range");

   // digit count stays within one to ten once conversion is done
   a_dig_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP || state_ff == ST_EMIT) |->
         (dig_cnt_ff >= DIGITS_ONE && dig_cnt_ff <= DIGITS_ALL))
      else $error("digit count out of range");

   // only a sign or a decimal digit leaves the block
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_char_ff == sitda_pkg::CHAR_MINUS ||
         (rsp_char_ff >= sitda_pkg::CHAR_ZERO &&
          rsp_char_ff <= sitda_pkg::CHAR_ZERO + 8'd9)))
      else $error("illegal output character");

   // the sign is never the last character
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_char_ff == sitda_pkg::CHAR_MINUS) |-> !rsp_last_ff)
      else $error("sign flagged as last character");
`endif

endmodule

// ----- bench/signed_int_to_decimal_ascii_core_tb.sv -----
module signed_int_to_decimal_ascii_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RADIX       = 10;
   localparam int unsigned MAX_WAIT    = 14;
   localparam int unsigned ITEM_CYCLES = 45;
   localparam int unsigned STALL_LIMIT = 2000;

   // one character beat of the decimal text
   typedef struct packed {
      logic [sitda_pkg::CHAR_W-1:0] text_char;
      logic                         is_last;
   } text_beat_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [sitda_pkg::VALUE_W-1:0] req_value;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [sitda_pkg::CHAR_W-1:0]         rsp_text_char;
   logic                                 rsp_is_last;

   text_beat_type pending_text[$];
   int            error_count;
   bit            steady_flow;

   signed_int_to_decimal_ascii_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_is_last   (rsp_is_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // expected characters of one integer, sign first then digits msd first
   function automatic void queue_decimal_text(input logic [sitda_pkg::VALUE_W-1:0] raw);
      logic [sitda_pkg::VALUE_W-1:0] mag;
      logic [sitda_pkg::DIGIT_W-1:0] digits[sitda_pkg::NUM_DIGITS];
      int                            nd;
      text_beat_type                 beat;
      mag = raw[sitda_pkg::VALUE_W-1] ? (sitda_pkg::VALUE_W'(0) - raw) : raw;
      nd  = 0;
      do begin
         digits[nd] = sitda_pkg::DIGIT_W'(mag % RADIX);
         mag        = mag / RADIX;
         nd++;
      end while (mag != 0 && nd < sitda_pkg::NUM_DIGITS);
      if (raw[sitda_pkg::VALUE_W-1]) begin
         beat.text_char = sitda_pkg::CHAR_MINUS;
         beat.is_last   = 1'b0;
         pending_text.push_back(beat);
      end
      for (int k = nd - 1; k >= 0; k--) begin
         beat.text_char = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digits[k]);
         beat.is_last   = (k == 0);
         pending_text.push_back(beat);
      end
   endfunction

   // idle cycles before a beat, none while the flow is steady
   function automatic int unsigned pick_wait();
      if (steady_flow || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // random integer, spread over digit counts and decade edges
   function automatic logic signed [sitda_pkg::VALUE_W-1:0] pick_value();
      logic signed [sitda_pkg::VALUE_W-1:0] v;
      longint                               lim;
      int unsigned                          d;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            d   = $urandom_range(1, 9);
            lim = 10 ** d - 1;
            v   = $urandom_range(0, int'(lim));
            if ($urandom_range(0, 1)) v = -v;
         end
         2: begin
            d = $urandom_range(0, 9);
            v = sitda_pkg::VALUE_W'(10 ** d) + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) v = -v;
         end
         default: begin
            if ($urandom_range(0, 1))
               v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
            else
               v = 32'sh8000_0000 + $urandom_range(0, 3);
         end
      endcase
      return v;
   endfunction

   // send one integer; valid stays up between beats when no gap is drawn
   task automatic send_value(input logic signed [sitda_pkg::VALUE_W-1:0] v);
      int unsigned gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      queue_decimal_text(v);
   endtask

   // hold off the sender until all text has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_text.size() != 0);
   endtask

   task automatic test_directed();
      logic signed [sitda_pkg::VALUE_W-1:0] vals[$];
      vals = '{0, 1, -1, 5, -5, 9, 10, -10, 99, 100, -100,
               999999999, 1000000000, -999999999, -1000000000,
               1234567890, -1234567890, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF,
               32'sh8000_0000, 32'sh5555_5555, 32'shAAAA_AAAA};
      foreach (vals[i]) send_value(vals[i]);
   endtask

   task automatic test_random_values(input int n);
      repeat (n) send_value(pick_value());
   endtask

   task automatic test_steady_stream(input int n);
      steady_flow = 1'b1;
      repeat (n) send_value(pick_value());
      steady_flow = 1'b0;
   endtask

   task automatic test_pause_until_drained(input int n);
      repeat (n) begin
         send_value(pick_value());
         wait_drained();
      end
   endtask

   // response side: random stall before each beat
   initial begin
      int unsigned stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      repeat (pick_wait()) @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!rsp_valid);
         stall = pick_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each character beat with the oldest expected one
   always @(posedge clock) begin
      text_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_text.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                     $time, rsp_text_char, rsp_is_last);
         end else begin
            want = pending_text.pop_front();
            if (rsp_text_char !== want.text_char) begin
               error_count++;
               $display("%0t: text_char mismatch, expected %0d actual %0d",
                        $time, want.text_char, rsp_text_char);
            end
            if (rsp_is_last !== want.is_last) begin
               error_count++;
               $display("%0t: is_last mismatch, expected %0b actual %0b",
                        $time, want.is_last, rsp_is_last);
            end
         end
      end
   end

   // watchdog on cycles with no beat on either side
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) break;
      end
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      error_count = 0;
      steady_flow = 1'b0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_values(80);
      test_steady_stream(40);
      test_pause_until_drained(10);
      test_random_values(20);

      // let the last text come out, then watch for stray beats
      wait_drained();
      repeat (ITEM_CYCLES + 15) @(posedge clock);
      if (error_count == 0 && pending_text.size() == 0) begin
         $display("Regression PASS");
      end else begin
         if (pending_text.size() != 0) begin
            $display("%0t: missing beats, expected %0d more, actual 0",
                     $time, pending_text.size());
         end
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
